// ===== sv/count_min_sketch_engine_macros.svh =====
// Assertion macros used by the count-min sketch engine back end.
`ifndef COUNT_MIN_SKETCH_ENGINE_MACROS_SVH
`define COUNT_MIN_SKETCH_ENGINE_MACROS_SVH

// Check a consequence in the same cycle as its antecedent.
`define CMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define CMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cms_pkg.sv =====
// Shared types and constants of the count-min sketch engine.
package cms_pkg;

   // Field widths of one request word
   localparam int OPCODE_W = 2;
   localparam int KEY_W    = 32;

   // Opcodes
   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   // FNV-1a hash constants
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [7:0]  BYTE_MASK = 8'hff;

   // Seed register file
   localparam int SEED_COUNT  = 4;
   localparam int CSR_INDEX_W = 3;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One queued command
   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [KEY_W-1:0]    key_value;
   } cms_item_type;

endpackage

// ===== sv/cms_front.sv =====
// Front end: accepts request words, drops unused opcodes, forwards commands.
module cms_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cms_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [cms_pkg::KEY_W-1:0]     req_key_value,
   input  logic                          clearing,
   output logic                          push_valid,
   input  logic                          push_ready,
   output cms_pkg::cms_item_type         push_item
);

   logic op_used;

   // Classify: the unused opcode is taken and dropped without touching the queue
   assign op_used = (req_opcode != cms_pkg::OP_UNUSED);

   // Hold off requests during the clearing pass, and commands while the queue is full
   assign req_tready = !clearing && (push_ready || !op_used);
   assign push_valid = req_tvalid && !clearing && op_used;

   assign push_item.opcode    = req_opcode;
   assign push_item.key_value = req_key_value;

endmodule

// ===== sv/cms_queue.sv =====
// Short command queue that decouples the front end from the back end.
module cms_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  cms_pkg::cms_item_type push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output cms_pkg::cms_item_type pop_item
);

   cms_pkg::cms_item_type                slot_ff [cms_pkg::QUEUE_DEPTH];
   logic [cms_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cms_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cms_pkg::QUEUE_CNT_W-1:0]      count_ff, count_in;
   logic                                 do_push, do_pop;

   assign push_ready = (count_ff != cms_pkg::QUEUE_CNT_W'(cms_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/cms_back.sv =====
// Back end: per-row hashing, counter memory read-modify-write and query minimum.
`include "count_min_sketch_engine_macros.svh"

module cms_back #(
   parameter int ROWS          = 4,
   parameter int COLUMNS       = 2048,
   parameter int COUNTER_WIDTH = 31
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic [cms_pkg::SEED_COUNT-1:0][31:0]         seeds,
   input  logic                                         pop_valid,
   output logic                                         pop_ready,
   input  cms_pkg::cms_item_type                        pop_item,
   output logic                                         rsp_valid,
   input  logic                                         rsp_ready,
   output logic [COUNTER_WIDTH-1:0]                     rsp_estimate,
   output logic                                         clearing
);

   localparam int  ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int  COL_W    = $clog2(COLUMNS);
   localparam int  DEPTH    = ROWS * COLUMNS;
   localparam int  ADDR_W   = $clog2(DEPTH);
   localparam bit  COL_POW2 = ((COLUMNS & (COLUMNS - 1)) == 0);
   localparam logic [COUNTER_WIDTH-1:0] CTR_MAX = {COUNTER_WIDTH{1'b1}};
   localparam logic [31:0] COL_DIV   = 32'(COLUMNS);
   localparam logic [31:0] COL_RECIP = 32'((64'd1 << 32) / COLUMNS);

   // Sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH   = 3'd2;
   localparam logic [2:0] ST_MOD    = 3'd3;
   localparam logic [2:0] ST_ADDR   = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;
   localparam logic [2:0] ST_UPDATE = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [2:0]                      state_ff, state_in;
   logic [ADDR_W-1:0]               clr_cnt_ff, clr_cnt_in;
   logic [ROW_W-1:0]                row_ff, row_in;
   logic [1:0]                      byte_cnt_ff, byte_cnt_in;
   logic [1:0]                      mod_step_ff, mod_step_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [cms_pkg::OPCODE_W-1:0]    op_ff;
   logic [cms_pkg::KEY_W-1:0]       key_ff;
   logic [31:0]                     h_ff;
   logic [31:0]                     q_ff;
   logic [31:0]                     diff_ff;
   logic [COL_W-1:0]                rem_ff;
   logic [ADDR_W-1:0]               addr_ff;
   logic [COUNTER_WIDTH-1:0]        rd_data_ff;
   logic [COUNTER_WIDTH-1:0]        min_ff;
   logic [COUNTER_WIDTH-1:0]        est_ff;

   logic [COUNTER_WIDTH-1:0]        mem [DEPTH];

   logic                            load_item, rsp_load, mem_we, row_last;
   logic [ADDR_W-1:0]               mem_waddr;
   logic [COUNTER_WIDTH-1:0]        mem_wdata, upd_val, min_in;
   logic [31:0]                     hash_src, h_mult;
   logic [7:0]                      hash_byte;
   logic [63:0]                     recip_prod;
   logic [31:0]                     q_in, diff_in;
   logic [COL_W-1:0]                rem_in, col_sel;
   logic [ADDR_W-1:0]               addr_calc;
   logic                            row_over, op_wr, upd_end;

   assign row_last     = (row_ff == ROW_W'(ROWS - 1));
   assign pop_ready    = (state_ff == ST_IDLE);
   assign clearing     = (state_ff == ST_CLEAR);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = est_ff;

   // One FNV-1a byte step: xor the byte in, multiply by the prime
   assign hash_src  = key_ff ^ seeds[2'(row_ff)];
   assign hash_byte = 8'(hash_src >> {byte_cnt_ff, 3'b000}) & cms_pkg::BYTE_MASK;
   assign h_mult    = 32'((h_ff ^ {24'd0, hash_byte}) * cms_pkg::FNV_PRIME);

   // Column remainder by reciprocal multiply: the quotient estimate is low by at
   // most one, so one compare and subtract finishes it
   assign recip_prod = 64'(h_ff) * 64'(COL_RECIP);
   assign q_in       = recip_prod[63:32];
   assign diff_in    = h_ff - 32'(q_ff * COL_DIV);
   assign rem_in     = (diff_ff >= COL_DIV) ? COL_W'(diff_ff - COL_DIV) : COL_W'(diff_ff);

   // Column select and flat counter address
   assign col_sel   = COL_POW2 ? h_ff[COL_W-1:0] : rem_ff;
   assign addr_calc = ADDR_W'(ADDR_W'(row_ff) * ADDR_W'(COLUMNS)) + ADDR_W'(col_sel);

   // Saturating increment, clamped decrement, running minimum
   always_comb begin
      if (op_ff == cms_pkg::OP_INSERT) begin
         upd_val = (rd_data_ff == CTR_MAX) ? rd_data_ff : rd_data_ff + 1'b1;
      end else begin
         upd_val = (rd_data_ff == '0) ? rd_data_ff : rd_data_ff - 1'b1;
      end
      min_in = (rd_data_ff < min_ff) ? rd_data_ff : min_ff;
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      row_in      = row_ff;
      byte_cnt_in = byte_cnt_ff;
      mod_step_in = mod_step_ff;
      load_item   = 1'b0;
      rsp_load    = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = addr_ff;
      mem_wdata   = upd_val;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               load_item   = 1'b1;
               row_in      = '0;
               byte_cnt_in = '0;
               state_in    = ST_HASH;
            end
         end
         ST_HASH: begin
            byte_cnt_in = byte_cnt_ff + 1'b1;
            if (byte_cnt_ff == 2'd3) begin
               if (COL_POW2) begin
                  state_in = ST_ADDR;
               end else begin
                  mod_step_in = '0;
                  state_in    = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            mod_step_in = mod_step_ff + 1'b1;
            if (mod_step_ff == 2'd2) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we = (op_ff != cms_pkg::OP_QUERY);
            if (row_last) begin
               state_in = (op_ff == cms_pkg::OP_QUERY) ? ST_DONE : ST_IDLE;
            end else begin
               row_in      = row_ff + 1'b1;
               byte_cnt_in = '0;
               state_in    = ST_HASH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result word until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         row_ff       <= '0;
         byte_cnt_ff  <= '0;
         mod_step_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         row_ff       <= row_in;
         byte_cnt_ff  <= byte_cnt_in;
         mod_step_ff  <= mod_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (load_item) begin
         op_ff  <= pop_item.opcode;
         key_ff <= pop_item.key_value;
         min_ff <= CTR_MAX;
         h_ff   <= cms_pkg::FNV_BASIS;
      end
      if (state_ff == ST_HASH) begin
         h_ff <= h_mult;
      end
      if (state_ff == ST_MOD) begin
         if (mod_step_ff == 2'd0) begin
            q_ff <= q_in;
         end
         if (mod_step_ff == 2'd1) begin
            diff_ff <= diff_in;
         end
         if (mod_step_ff == 2'd2) begin
            rem_ff <= rem_in;
         end
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_calc;
      end
      if (state_ff == ST_UPDATE) begin
         if (op_ff == cms_pkg::OP_QUERY) begin
            min_ff <= min_in;
         end
         if (!row_last) begin
            h_ff <= cms_pkg::FNV_BASIS;
         end
      end
      if (rsp_load) begin
         est_ff <= min_ff;
      end
   end

   // Counter memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[addr_ff];
   end

   // Conditions watched by the checks below
   assign row_over = (row_ff > ROW_W'(ROWS - 1));
   assign op_wr    = mem_we && (state_ff != ST_CLEAR) &&
                     (op_ff != cms_pkg::OP_INSERT) && (op_ff != cms_pkg::OP_DELETE);
   assign upd_end  = (state_ff == ST_UPDATE) && row_last && (op_ff != cms_pkg::OP_QUERY);

   `CMS_ASSERT_NOW(a_row_in_range, clock, reset, 1'b1, !row_over, "row index past last row")
   `CMS_ASSERT_NOW(a_write_op, clock, reset, op_wr, 1'b0, "stray counter write")
   `CMS_ASSERT_NEXT(a_rsp_load, clock, reset, rsp_load, rsp_valid && pop_ready, "result lost")
   `CMS_ASSERT_NEXT(a_update_ends, clock, reset, upd_end, pop_ready, "no return to idle")

endmodule

// ===== sv/count_min_sketch_engine.sv =====
// Top level of the count-min sketch engine: seed registers and channel wiring.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_tvalid/req_tready   tuser opcode, tdata key_value
//   rsp_      out        rsp_tvalid/rsp_tready   tdata estimate (query only)
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data (row seeds)
//
// Each command passes through the back end one row at a time: the hash step over the
// four key bytes, the reciprocal-multiply column remainder when COLUMNS is not a
// power of two, the address step, the counter memory read and, for insert and
// delete, its write-back; a query then loads the result word. A new command is
// taken only once the last is through. After reset the counter memory is swept to
// zero; no request is taken then. Up to two commands queue ahead of the back end.
module count_min_sketch_engine #(
   parameter int ROWS          = 4,
   parameter int COLUMNS       = 2048,
   parameter int COUNTER_WIDTH = 31
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // [31:0] key_value
   input  logic [cms_pkg::KEY_W-1:0]                  req_tdata,
   // [1:0] opcode
   input  logic [cms_pkg::OPCODE_W-1:0]               req_tuser,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // [COUNTER_WIDTH-1:0] estimate, zero padded to whole bytes
   output logic [((COUNTER_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [cms_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [31:0]                                csr_data
);

   localparam int RSP_W = ((COUNTER_WIDTH + 7) / 8) * 8;

   logic [cms_pkg::SEED_COUNT-1:0][31:0] seed_ff;
   logic                                 clearing;
   logic                                 push_valid, push_ready;
   logic                                 pop_valid, pop_ready;
   cms_pkg::cms_item_type                push_item, pop_item;
   logic [COUNTER_WIDTH-1:0]             rsp_estimate;

   // Seed registers; writes beyond the last seed are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= '0;
      end else if (csr_valid && (csr_index < cms_pkg::CSR_INDEX_W'(cms_pkg::SEED_COUNT))) begin
         seed_ff[2'(csr_index)] <= csr_data;
      end
   end

   cms_front u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_opcode    (req_tuser),
      .req_key_value (req_tdata),
      .clearing      (clearing),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   cms_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cms_back #(
      .ROWS          (ROWS),
      .COLUMNS       (COLUMNS),
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .seeds        (seed_ff),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_item     (pop_item),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_estimate (rsp_estimate),
      .clearing     (clearing)
   );

   assign rsp_tdata = RSP_W'(rsp_estimate);

endmodule
